// ===== src/hsp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsp_pkg
// shared types, constants and helpers for the sphere point generator
// ----------------------------------------------------------------------------
package hsp_pkg;

    localparam int INDEX_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int CSUB_W         = 32;
    localparam int CORDIC_STEPS   = 16;
    localparam int CORDIC_W       = 34;
    localparam int ANGLE_W        = 33;
    localparam logic [15:0] GAIN_Q16     = 16'd39797;
    localparam logic [15:0] COUNT_RESET  = 16'd256;
    localparam logic [31:0] ROOT_ONE     = 32'h4000_0000;

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_REM  = 8'b0000_0010,
        S_FRAC = 8'b0000_0100,
        S_SQR  = 8'b0000_1000,
        S_ROOT = 8'b0001_0000,
        S_GAIN = 8'b0010_0000,
        S_ROT  = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    typedef struct packed {
        logic       load;
        logic       step;
        logic [3:0] idx;
    } t_cordic_ctl;

    function automatic logic [31:0] atan_turn(input logic [3:0] i);
        logic [31:0] a;
        begin
            unique case (i)
                4'd0:  a = 32'h20000000;
                4'd1:  a = 32'h12E4051E;
                4'd2:  a = 32'h09FB385B;
                4'd3:  a = 32'h051111D4;
                4'd4:  a = 32'h028B0D43;
                4'd5:  a = 32'h0145D7E1;
                4'd6:  a = 32'h00A2F61E;
                4'd7:  a = 32'h00517C55;
                4'd8:  a = 32'h0028BE53;
                4'd9:  a = 32'h00145F2F;
                4'd10: a = 32'h000A2F98;
                4'd11: a = 32'h000517CC;
                4'd12: a = 32'h00028BE6;
                4'd13: a = 32'h000145F3;
                4'd14: a = 32'h0000A2FA;
                default: a = 32'h0000517D;
            endcase
            return a;
        end
    endfunction

    function automatic logic signed [15:0] sat16(input logic signed [18:0] a);
        begin
            if (a > 19'sd32767) begin
                return 16'sh7FFF;
            end else if (a < -19'sd32768) begin
                return 16'sh8000;
            end
            return a[15:0];
        end
    endfunction

endpackage
`default_nettype wire

// ===== src/hsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsp interfaces
// request, result and register write channels
// ----------------------------------------------------------------------------
interface hsp_in_if;
    logic valid;
    logic ready;
    logic restart;
    logic plane_mode;
    modport source (output valid, restart, plane_mode, input ready);
    modport sink   (input valid, restart, plane_mode, output ready);
endinterface

interface hsp_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] coord_x;
    logic [15:0] coord_y;
    logic [15:0] coord_z;
    logic [15:0] plane_u;
    logic [15:0] plane_v;
    logic [15:0] point_number;
    modport source (output valid, coord_x, coord_y, coord_z, plane_u, plane_v,
                    point_number, input ready);
    modport sink   (input valid, coord_x, coord_y, coord_z, plane_u, plane_v,
                    point_number, output ready);
endinterface

interface hsp_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== src/hsp_csub.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsp_csub
// shared compare and subtract unit for remainder, fraction and root steps
// ----------------------------------------------------------------------------
module hsp_csub (
    input  wire logic [hsp_pkg::CSUB_W-1:0] i_a,
    input  wire logic [hsp_pkg::CSUB_W-1:0] i_b,
    output logic                            o_ge,
    output logic [hsp_pkg::CSUB_W-1:0]      o_diff
);
    logic [hsp_pkg::CSUB_W:0] w_sub;

    assign w_sub  = {1'b0, i_a} - {1'b0, i_b};
    assign o_ge   = ~w_sub[hsp_pkg::CSUB_W];
    assign o_diff = w_sub[hsp_pkg::CSUB_W-1:0];
endmodule
`default_nettype wire

// ===== src/hsp_cordic.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsp_cordic
// one rotation step per cycle while step is set, start vector scaled by gain compensation
// ----------------------------------------------------------------------------
module hsp_cordic (
    input  wire logic                                i_clk,
    input  wire hsp_pkg::t_cordic_ctl                i_ctl,
    input  wire logic [16:0]                         i_radius,
    input  wire logic [29:0]                         i_angle,
    output logic signed [hsp_pkg::CORDIC_W-1:0]      o_x,
    output logic signed [hsp_pkg::CORDIC_W-1:0]      o_y
);
    logic signed [hsp_pkg::CORDIC_W-1:0] r_x, r_y, n_x, n_y, w_dx, w_dy;
    logic signed [hsp_pkg::ANGLE_W-1:0]  r_r, n_r, w_at;
    logic [32:0]                         w_prod;

    assign w_prod = 33'(i_radius) * 33'(hsp_pkg::GAIN_Q16);
    assign w_dx   = r_y >>> i_ctl.idx;
    assign w_dy   = r_x >>> i_ctl.idx;
    assign w_at   = $signed({1'b0, hsp_pkg::atan_turn(i_ctl.idx)});

    always_comb begin
        n_x = r_x;
        n_y = r_y;
        n_r = r_r;
        if (i_ctl.load) begin
            n_x = $signed({1'b0, w_prod});
            n_y = '0;
            n_r = $signed({3'b000, i_angle});
        end else if (i_ctl.step) begin
            if (!r_r[hsp_pkg::ANGLE_W-1]) begin
                n_x = r_x - w_dx;
                n_y = r_y + w_dy;
                n_r = r_r - w_at;
            end else begin
                n_x = r_x + w_dx;
                n_y = r_y - w_dy;
                n_r = r_r + w_at;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_x <= n_x;
        r_y <= n_y;
        r_r <= n_r;
    end

    assign o_x = r_x;
    assign o_y = r_y;
endmodule
`default_nettype wire

// ===== src/hammersley_sphere_point_generator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hammersley_sphere_point_generator_unit
// base-2 hammersley points on the unit sphere or the unit square
// ----------------------------------------------------------------------------
// Each request beat makes one point from the stored index and then advances
// it. One compare-subtract unit runs the remainder, the azimuth fraction
// and, for a sphere point, the square root one bit per cycle; a sphere
// point then takes a sixteen-step rotation. One request is in work at a
// time; a finished point sits in the result register so the next request
// can start at once, but a point that finds that register still full waits
// in the done state until it is taken.
// ----------------------------------------------------------------------------
module hammersley_sphere_point_generator_unit #(
    parameter int INDEX_BITS = hsp_pkg::INDEX_BITS_DEF,
    parameter int FRAC_BITS  = hsp_pkg::FRAC_BITS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    hsp_in_if.sink     i_in,
    hsp_cfg_if.sink    i_cfg,
    hsp_out_if.source  o_out
);
    hsp_pkg::t_state r_state, n_state;

    logic [INDEX_BITS-1:0] r_idx, r_k;
    logic [INDEX_BITS:0]   r_num;
    logic [15:0]           r_pc;
    logic                  r_plane;
    logic [5:0]            r_cnt;
    logic [17:0]           r_rem;
    logic [FRAC_BITS-1:0]  r_q;
    logic [31:0]           r_sa, r_root, r_bit;

    logic        r_ov;
    logic [15:0] r_ox, r_oy, r_oz, r_ou, r_ovv, r_opn;

    logic [16:0] w_d;
    logic [15:0] w_n;
    logic [hsp_pkg::CSUB_W-1:0] w_a, w_b, w_diff;
    logic        w_ge;
    logic        w_acc;

    logic [INDEX_BITS-1:0] w_rev;
    logic [15:0] w_u16, w_pn, w_v16;
    logic [31:0] w_phase;
    logic signed [15:0] w_z;
    logic signed [31:0] w_zz;

    hsp_pkg::t_cordic_ctl w_cctl;
    logic signed [hsp_pkg::CORDIC_W-1:0] w_cx, w_cy;
    logic signed [hsp_pkg::CORDIC_W-1:0] w_cr, w_sr;
    logic signed [18:0] w_c, w_s, w_fx, w_fy;

    always_comb begin
        for (int i = 0; i < INDEX_BITS; i++) begin
            w_rev[i] = r_k[INDEX_BITS-1-i];
        end
    end

    generate
        if (INDEX_BITS >= 16) begin : g_wide
            assign w_u16 = w_rev[INDEX_BITS-1 -: 16];
            assign w_pn  = r_k[15:0];
        end else begin : g_narrow
            assign w_u16 = {w_rev, {(16-INDEX_BITS){1'b0}}};
            assign w_pn  = {{(16-INDEX_BITS){1'b0}}, r_k};
        end
        if (FRAC_BITS == 32) begin : g_ph_full
            assign w_phase = r_q;
        end else begin : g_ph_part
            assign w_phase = {r_q, {(32-FRAC_BITS){1'b0}}};
        end
    endgenerate

    assign w_v16 = w_phase[31:16];
    assign w_z   = $signed({~w_u16[15], w_u16[14:0]});
    assign w_zz  = 32'(w_z) * 32'(w_z);
    assign w_n   = (r_pc == 16'd0) ? 16'd1 : r_pc;
    assign w_d   = {w_n, 1'b0};

    always_comb begin
        w_a = '0;
        w_b = hsp_pkg::CSUB_W'(w_d);
        unique case (r_state)
            hsp_pkg::S_REM:  w_a = hsp_pkg::CSUB_W'({r_rem[16:0], r_num[INDEX_BITS]});
            hsp_pkg::S_FRAC: w_a = hsp_pkg::CSUB_W'({r_rem[16:0], 1'b0});
            hsp_pkg::S_ROOT: begin
                w_a = r_sa;
                w_b = r_root + r_bit;
            end
            default: w_a = '0;
        endcase
    end

    hsp_csub u_csub (
        .i_a    (w_a),
        .i_b    (w_b),
        .o_ge   (w_ge),
        .o_diff (w_diff)
    );

    assign w_cctl.load = (r_state == hsp_pkg::S_GAIN);
    assign w_cctl.step = (r_state == hsp_pkg::S_ROT);
    assign w_cctl.idx  = 4'd15 - r_cnt[3:0];

    hsp_cordic u_cordic (
        .i_clk    (i_clk),
        .i_ctl    (w_cctl),
        .i_radius (r_root[16:0]),
        .i_angle  (w_phase[29:0]),
        .o_x      (w_cx),
        .o_y      (w_cy)
    );

    assign w_cr = (w_cx + 34'sd32768) >>> 16;
    assign w_sr = (w_cy + 34'sd32768) >>> 16;
    assign w_c  = w_cr[18:0];
    assign w_s  = w_sr[18:0];

    always_comb begin
        unique case (w_phase[31:30])
            2'd0: begin w_fx = w_c;  w_fy = w_s;  end
            2'd1: begin w_fx = -w_s; w_fy = w_c;  end
            2'd2: begin w_fx = -w_c; w_fy = -w_s; end
            default: begin w_fx = w_s; w_fy = -w_c; end
        endcase
    end

    assign w_acc       = i_in.valid && i_in.ready;
    assign i_in.ready  = (r_state == hsp_pkg::S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            hsp_pkg::S_IDLE: if (w_acc) n_state = hsp_pkg::S_REM;
            hsp_pkg::S_REM:  if (r_cnt == 6'd0) n_state = hsp_pkg::S_FRAC;
            hsp_pkg::S_FRAC: begin
                if (r_cnt == 6'd0) n_state = r_plane ? hsp_pkg::S_DONE : hsp_pkg::S_SQR;
            end
            hsp_pkg::S_SQR:  n_state = hsp_pkg::S_ROOT;
            hsp_pkg::S_ROOT: if (r_cnt == 6'd0) n_state = hsp_pkg::S_GAIN;
            hsp_pkg::S_GAIN: n_state = hsp_pkg::S_ROT;
            hsp_pkg::S_ROT:  if (r_cnt == 6'd0) n_state = hsp_pkg::S_DONE;
            hsp_pkg::S_DONE: if (!r_ov || o_out.ready) n_state = hsp_pkg::S_IDLE;
            default:         n_state = hsp_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= hsp_pkg::S_IDLE;
            r_idx   <= '0;
            r_pc    <= hsp_pkg::COUNT_RESET;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg.valid) begin
                r_pc <= i_cfg.data;
            end
            if (w_acc) begin
                r_idx <= (i_in.restart ? '0 : r_idx) + INDEX_BITS'(1);
            end
            if (r_state == hsp_pkg::S_DONE && (!r_ov || o_out.ready)) begin
                r_ov <= 1'b1;
            end else if (o_out.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            hsp_pkg::S_IDLE: begin
                r_k     <= i_in.restart ? '0 : r_idx;
                r_num   <= {(i_in.restart ? {INDEX_BITS{1'b0}} : r_idx), 1'b1};
                r_plane <= i_in.plane_mode;
                r_rem   <= '0;
                r_cnt   <= 6'(INDEX_BITS);
            end
            hsp_pkg::S_REM: begin
                r_num <= r_num << 1;
                r_rem <= w_ge ? w_diff[17:0] : w_a[17:0];
                r_cnt <= (r_cnt == 6'd0) ? 6'(FRAC_BITS - 1) : r_cnt - 6'd1;
            end
            hsp_pkg::S_FRAC: begin
                r_q   <= {r_q[FRAC_BITS-2:0], w_ge};
                r_rem <= w_ge ? w_diff[17:0] : w_a[17:0];
                r_cnt <= r_cnt - 6'd1;
            end
            hsp_pkg::S_SQR: begin
                r_sa   <= hsp_pkg::ROOT_ONE - 32'(w_zz);
                r_root <= '0;
                r_bit  <= hsp_pkg::ROOT_ONE;
                r_cnt  <= 6'd15;
            end
            hsp_pkg::S_ROOT: begin
                if (w_ge) begin
                    r_sa   <= w_diff;
                    r_root <= (r_root >> 1) + r_bit;
                end else begin
                    r_root <= r_root >> 1;
                end
                r_bit <= r_bit >> 2;
                r_cnt <= r_cnt - 6'd1;
            end
            hsp_pkg::S_GAIN: r_cnt <= 6'd15;
            hsp_pkg::S_ROT:  r_cnt <= r_cnt - 6'd1;
            hsp_pkg::S_DONE: begin
                if (!r_ov || o_out.ready) begin
                    r_ox  <= r_plane ? 16'd0 : hsp_pkg::sat16(w_fx);
                    r_oy  <= r_plane ? 16'd0 : hsp_pkg::sat16(w_fy);
                    r_oz  <= w_z;
                    r_ou  <= w_u16;
                    r_ovv <= w_v16;
                    r_opn <= w_pn;
                end
            end
            default: r_cnt <= r_cnt;
        endcase
    end

    assign o_out.valid        = r_ov;
    assign o_out.coord_x      = r_ox;
    assign o_out.coord_y      = r_oy;
    assign o_out.coord_z      = r_oz;
    assign o_out.plane_u      = r_ou;
    assign o_out.plane_v      = r_ovv;
    assign o_out.point_number = r_opn;
endmodule
`default_nettype wire

// ===== src/hsp_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hsp_checker
// port-level checks on the point generator
// ----------------------------------------------------------------------------
module hsp_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [15:0] i_coord_z,
    input wire logic [15:0] i_plane_u
);
    a_busy_after_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("request taken while a point is in work");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_coord_z))
        else $error("pending result dropped or changed");

    a_z_matches_u: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_coord_z == {~i_plane_u[15], i_plane_u[14:0]})
        else $error("z does not equal 2u-1");

    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind hammersley_sphere_point_generator_unit hsp_checker u_hsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_coord_z   (o_out.coord_z),
    .i_plane_u   (o_out.plane_u)
);
`default_nettype wire
